### src/bffa_pkg.sv
// bffa_pkg: shared constants, command codes and sequencer states of the
// bitmap first-fit sector allocator.
// Depends on nothing; used by the allocator, its monitor and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package bffa_pkg;

  // capacity and map geometry
  localparam int SECTORS      = 8192;
  localparam int WORD_BITS    = 64;
  localparam int MAX_RUN      = 255;
  localparam int FIRST_SEARCH = 2;
  localparam int MAP_WORDS    = (SECTORS + WORD_BITS - 1) / WORD_BITS;

  // widths
  localparam int START_W = 13;
  localparam int COUNT_W = 8;
  localparam int SEC_W   = 14;
  localparam int ADDR_W  = $clog2(MAP_WORDS);
  localparam int OFF_W   = $clog2(WORD_BITS);
  localparam int STEP_W  = 3;
  localparam int STEPS   = 1 << STEP_W;
  localparam int BYTE_W  = OFF_W - STEP_W;
  localparam int POS_W   = ADDR_W + BYTE_W;

  // port widths
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RESERVE = 2'd2,
    CMD_TEST    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXTEND,
    ST_WR_RD,
    ST_WR_MOD,
    ST_TEST_BIT,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

### src/bitmap_first_fit_sector_allocator.sv
// bitmap_first_fit_sector_allocator: used-sector bitmap with a high-water
// mark, serving allocate, free, reserve and test requests one at a time.
// Depends on bffa_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One request is taken at a time; s_tready is high only while the sequencer
// is idle, and a finished result waits in the output register while the
// next request is accepted. The bitmap is a 128 x 64 memory with one read
// and one write port; a valid bit per word makes it read as free after
// reset, so there is no clearing pass. Test reads the word that holds the
// sector and returns its bit. Free and reserve do one read-modify-write per
// map word that the range touches (at most 5 words). Allocate scans from
// sector 2 up to the high-water mark one byte of the map per cycle through
// a single 8-step run counter, then marks the run word by word and
// finishes. A zero-count allocate returns the mark.
module bitmap_first_fit_sector_allocator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // start_sector [12:0], sector_count [20:13], zero fill [23:21]
  input  wire logic [bffa_pkg::IN_DATA_W-1:0]    s_tdata,
  // command [1:0]
  input  wire logic [bffa_pkg::IN_USER_W-1:0]    s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // sector [13:0], is_used [14], status [15]
  output logic [bffa_pkg::OUT_DATA_W-1:0]        m_tdata
);

  bffa_pkg::state_t state, state_next;

  // request fields
  bffa_pkg::cmd_t                    in_cmd;
  logic [bffa_pkg::START_W-1:0]      in_start;
  logic [bffa_pkg::COUNT_W-1:0]      in_count;
  logic                              accept;

  // request registers
  bffa_pkg::cmd_t                    cmd_q;
  logic [bffa_pkg::START_W-1:0]      start_q;
  logic [bffa_pkg::COUNT_W-1:0]      count_q;

  // sequencer datapath
  logic [bffa_pkg::SEC_W-1:0]        high_water;
  logic [bffa_pkg::COUNT_W-1:0]      run_q;
  logic [bffa_pkg::ADDR_W-1:0]       word_idx;
  logic [bffa_pkg::BYTE_W-1:0]       byte_idx;
  logic [bffa_pkg::SEC_W-1:0]        lo, hi;
  logic [bffa_pkg::SEC_W-1:0]        res_sector;
  logic                              res_used;
  logic                              res_status;

  // map memory
  logic [bffa_pkg::WORD_BITS-1:0]    map_mem [bffa_pkg::MAP_WORDS];
  logic [bffa_pkg::MAP_WORDS-1:0]    map_valid;
  logic [bffa_pkg::WORD_BITS-1:0]    mem_q;
  logic                              valid_q;
  logic [bffa_pkg::WORD_BITS-1:0]    rd_word;
  logic                              rd_en;
  logic [bffa_pkg::ADDR_W-1:0]       rd_addr;
  logic                              wr_en;
  logic [bffa_pkg::WORD_BITS-1:0]    wr_data;

  // request decode
  logic [bffa_pkg::SEC_W-1:0]        start_end;
  logic [bffa_pkg::SEC_W-1:0]        free_end;
  logic                              count_zero;
  logic                              count_big;
  logic                              rsv_bad;
  logic                              hw_low;

  // scan step results
  logic [bffa_pkg::COUNT_W-1:0]      run_v;
  logic                              found_v;
  logic [bffa_pkg::SEC_W-1:0]        sec_v;
  logic [bffa_pkg::POS_W:0]          pos_next;
  logic                              scan_more;

  // extend check and range masks
  logic [bffa_pkg::SEC_W-1:0]        ext_end;
  logic                              ext_full;
  logic [bffa_pkg::SEC_W-1:0]        hi_m1;
  logic                              last_word;
  logic [bffa_pkg::OFF_W-1:0]        lo_off;
  logic [bffa_pkg::OFF_W-1:0]        hi_sh;
  logic [bffa_pkg::WORD_BITS-1:0]    mask;

  // unpack the request
  assign in_cmd   = bffa_pkg::cmd_t'(s_tuser);
  assign in_start = s_tdata[bffa_pkg::START_W-1:0];
  assign in_count = s_tdata[bffa_pkg::START_W +: bffa_pkg::COUNT_W];
  assign accept   = s_tvalid && s_tready;

  // range and limit checks on the incoming request
  always_comb begin
    start_end  = bffa_pkg::SEC_W'(in_start) + bffa_pkg::SEC_W'(in_count);
    free_end   = (start_end > bffa_pkg::SEC_W'(bffa_pkg::SECTORS))
               ? bffa_pkg::SEC_W'(bffa_pkg::SECTORS) : start_end;
    count_zero = (in_count == '0);
    count_big  = (32'(in_count) > bffa_pkg::MAX_RUN);
    rsv_bad    = count_big || (start_end > bffa_pkg::SEC_W'(bffa_pkg::SECTORS));
    hw_low     = (high_water <= bffa_pkg::SEC_W'(bffa_pkg::FIRST_SEARCH));
  end

  // registered word read; a word never written reads as all free
  assign rd_word = valid_q ? mem_q : '0;

  // one byte of the map per cycle through the run counter
  always_comb begin
    logic [bffa_pkg::START_W-1:0] pos_v;
    logic                         bit_v;
    run_v   = run_q;
    found_v = 1'b0;
    sec_v   = '0;
    for (int k = 0; k < bffa_pkg::STEPS; k++) begin
      pos_v = {word_idx, byte_idx, bffa_pkg::STEP_W'(k)};
      bit_v = rd_word[{byte_idx, bffa_pkg::STEP_W'(k)}];
      if (!found_v && pos_v >= bffa_pkg::START_W'(bffa_pkg::FIRST_SEARCH)
          && bffa_pkg::SEC_W'(pos_v) < high_water) begin
        if (bit_v) begin
          run_v = '0;
        end else begin
          run_v = run_v + 1'b1;
          if (run_v == count_q) begin
            found_v = 1'b1;
            sec_v   = bffa_pkg::SEC_W'(pos_v) + 1'b1 - bffa_pkg::SEC_W'(count_q);
          end
        end
      end
    end
    pos_next  = {1'b0, word_idx, byte_idx} + 1'b1;
    scan_more = (bffa_pkg::SEC_W'({pos_next, {bffa_pkg::STEP_W{1'b0}}}) < high_water);
  end

  // extend at the mark
  assign ext_end  = high_water + bffa_pkg::SEC_W'(count_q);
  assign ext_full = (ext_end > bffa_pkg::SEC_W'(bffa_pkg::SECTORS));

  // bit mask of the range within the current word
  always_comb begin
    hi_m1     = hi - 1'b1;
    last_word = (word_idx == hi_m1[bffa_pkg::OFF_W +: bffa_pkg::ADDR_W]);
    lo_off    = (word_idx == lo[bffa_pkg::OFF_W +: bffa_pkg::ADDR_W])
              ? lo[bffa_pkg::OFF_W-1:0] : '0;
    hi_sh     = last_word ? ~hi_m1[bffa_pkg::OFF_W-1:0] : '0;
    mask      = ({bffa_pkg::WORD_BITS{1'b1}} << lo_off)
              & ({bffa_pkg::WORD_BITS{1'b1}} >> hi_sh);
    wr_data   = (cmd_q == bffa_pkg::CMD_FREE) ? (rd_word & ~mask) : (rd_word | mask);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bffa_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            bffa_pkg::CMD_ALLOC: begin
              priority if (count_zero || count_big) state_next = bffa_pkg::ST_FINISH;
              else if (hw_low)                     state_next = bffa_pkg::ST_EXTEND;
              else                                 state_next = bffa_pkg::ST_SCAN;
            end
            bffa_pkg::CMD_FREE:
              state_next = count_zero ? bffa_pkg::ST_FINISH : bffa_pkg::ST_WR_RD;
            bffa_pkg::CMD_RESERVE:
              state_next = (count_zero || rsv_bad) ? bffa_pkg::ST_FINISH
                                                   : bffa_pkg::ST_WR_RD;
            bffa_pkg::CMD_TEST:
              state_next = bffa_pkg::ST_TEST_BIT;
            default: state_next = bffa_pkg::ST_IDLE;
          endcase
        end
      end
      bffa_pkg::ST_SCAN: begin
        priority if (found_v)   state_next = bffa_pkg::ST_WR_RD;
        else if (!scan_more)    state_next = bffa_pkg::ST_EXTEND;
        else                    state_next = bffa_pkg::ST_SCAN;
      end
      bffa_pkg::ST_EXTEND:
        state_next = ext_full ? bffa_pkg::ST_FINISH : bffa_pkg::ST_WR_RD;
      bffa_pkg::ST_WR_RD:
        state_next = bffa_pkg::ST_WR_MOD;
      bffa_pkg::ST_WR_MOD:
        state_next = last_word ? bffa_pkg::ST_FINISH : bffa_pkg::ST_WR_RD;
      bffa_pkg::ST_TEST_BIT:
        state_next = bffa_pkg::ST_FINISH;
      bffa_pkg::ST_FINISH:
        if (!m_tvalid || m_tready) state_next = bffa_pkg::ST_IDLE;
      default: state_next = bffa_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and memory port controls
  always_comb begin
    s_tready = (state == bffa_pkg::ST_IDLE);
    rd_en    = 1'b0;
    rd_addr  = word_idx;
    wr_en    = 1'b0;
    unique case (state)
      bffa_pkg::ST_IDLE: begin
        rd_en   = accept;
        rd_addr = (in_cmd == bffa_pkg::CMD_TEST)
                ? in_start[bffa_pkg::OFF_W +: bffa_pkg::ADDR_W] : '0;
      end
      bffa_pkg::ST_SCAN: begin
        rd_en   = !found_v && scan_more && (byte_idx == '1);
        rd_addr = word_idx + 1'b1;
      end
      bffa_pkg::ST_WR_RD:  rd_en = 1'b1;
      bffa_pkg::ST_WR_MOD: wr_en = 1'b1;
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= bffa_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // map memory, one read and one write port
  always_ff @(posedge clk) begin
    if (wr_en) map_mem[word_idx] <= wr_data;
    if (rd_en) mem_q <= map_mem[rd_addr];
  end

  // per-word valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (wr_en) map_valid[word_idx] <= 1'b1;
      if (rd_en) valid_q <= map_valid[rd_addr];
    end
  end

  // high-water mark, raised when a marked range ends past it
  always_ff @(posedge clk) begin
    if (rst) begin
      high_water <= '0;
    end else if (state == bffa_pkg::ST_WR_MOD && last_word
                 && cmd_q != bffa_pkg::CMD_FREE && hi > high_water) begin
      high_water <= hi;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    unique case (state)
      bffa_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_q      <= in_cmd;
          start_q    <= in_start;
          count_q    <= in_count;
          run_q      <= '0;
          byte_idx   <= '0;
          lo         <= bffa_pkg::SEC_W'(in_start);
          hi         <= (in_cmd == bffa_pkg::CMD_FREE) ? free_end : start_end;
          word_idx   <= (in_cmd == bffa_pkg::CMD_ALLOC) ? '0
                      : in_start[bffa_pkg::OFF_W +: bffa_pkg::ADDR_W];
          res_sector <= (in_cmd == bffa_pkg::CMD_ALLOC && count_zero) ? high_water : '0;
          res_used   <= 1'b0;
          res_status <= ((in_cmd == bffa_pkg::CMD_ALLOC && !count_zero && count_big)
                      || (in_cmd == bffa_pkg::CMD_RESERVE && !count_zero && rsv_bad));
        end
      end
      bffa_pkg::ST_SCAN: begin
        run_q <= run_v;
        if (found_v) begin
          lo         <= sec_v;
          hi         <= sec_v + bffa_pkg::SEC_W'(count_q);
          res_sector <= sec_v;
          word_idx   <= sec_v[bffa_pkg::OFF_W +: bffa_pkg::ADDR_W];
        end else begin
          {word_idx, byte_idx} <= pos_next[bffa_pkg::POS_W-1:0];
        end
      end
      bffa_pkg::ST_EXTEND: begin
        if (ext_full) begin
          res_status <= 1'b1;
        end else begin
          lo         <= high_water;
          hi         <= ext_end;
          res_sector <= high_water;
          word_idx   <= high_water[bffa_pkg::OFF_W +: bffa_pkg::ADDR_W];
        end
      end
      bffa_pkg::ST_WR_MOD: begin
        if (!last_word) word_idx <= word_idx + 1'b1;
      end
      bffa_pkg::ST_TEST_BIT: begin
        res_used <= rd_word[start_q[bffa_pkg::OFF_W-1:0]];
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == bffa_pkg::ST_FINISH && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bffa_pkg::ST_FINISH && (!m_tvalid || m_tready)) begin
      m_tdata <= {res_status, res_used, res_sector};
    end
  end

`ifndef SYNTH
  // the mark only grows
  a_hw_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> high_water >= $past(high_water))
    else $error("high-water mark decreased");

  // the mark stays within capacity
  a_hw_range: assert property (@(posedge clk) disable iff (rst)
    high_water <= bffa_pkg::SEC_W'(bffa_pkg::SECTORS))
    else $error("high-water mark past capacity");

  // the run counter never passes the requested length while scanning
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    state == bffa_pkg::ST_SCAN |-> run_q < count_q)
    else $error("scan run counter overran the request");

  // a full status carries no sector and no test bit
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[15] |-> m_tdata[14:0] == '0)
    else $error("full status with nonzero payload");

  // writes only land inside the marked range
  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> lo < hi && word_idx >= lo[bffa_pkg::OFF_W +: bffa_pkg::ADDR_W])
    else $error("map write outside the request range");
`endif

endmodule

`default_nettype wire

### bench/sector_alloc_monitor.sv
// sector_alloc_monitor: watches both stream channels of the sector allocator,
// keeps its own copy of the used-sector map and high-water mark, and checks
// every reply field by field. Depends on bffa_pkg.
`timescale 1ns / 1ps

module sector_alloc_monitor (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  input  wire logic                           s_tready,
  // start_sector [12:0], sector_count [20:13], zero fill [23:21]
  input  wire logic [bffa_pkg::IN_DATA_W-1:0] s_tdata,
  // command [1:0]
  input  wire logic [bffa_pkg::IN_USER_W-1:0] s_tuser,
  input  wire logic                           m_tvalid,
  input  wire logic                           m_tready,
  // sector [13:0], is_used [14], status [15]
  input  wire logic [bffa_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                                  errors,
  output int                                  pending
);
  import bffa_pkg::*;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [SEC_W-1:0] sector;
    logic             is_used;
    logic             status;
  } reply_fields_t;

  // shadow allocator state
  bit            sector_used [SECTORS];
  int unsigned   water_mark;
  reply_fields_t expected_replies [$];

  // set or clear a range, clipped at capacity
  function automatic void write_sectors(int unsigned from, int unsigned count, bit val);
    int unsigned i;
    for (i = from; i < from + count && i < SECTORS; i++) sector_used[i] = val;
  endfunction

  // mark a range used and raise the mark
  function automatic void claim_sectors(int unsigned from, int unsigned count);
    write_sectors(from, count, 1'b1);
    if (from + count > water_mark) water_mark = from + count;
  endfunction

  // expected reply of one request, updating the shadow state
  function automatic reply_fields_t predict_reply(cmd_t cmd, int unsigned start,
                                                  int unsigned count);
    reply_fields_t r;
    int unsigned   run;
    int unsigned   i;
    bit            found;
    r = '0;
    r.status = STATUS_DONE;
    case (cmd)
      CMD_ALLOC: begin
        if (count == 0) begin
          r.sector = SEC_W'(water_mark);
        end else if (count > MAX_RUN) begin
          r.status = STATUS_FULL;
        end else begin
          // first fit between the search floor and the mark
          run = 0;
          found = 1'b0;
          for (i = FIRST_SEARCH; i < water_mark && !found; i++) begin
            if (sector_used[i]) begin
              run = 0;
            end else begin
              run++;
              if (run == count) begin
                r.sector = SEC_W'(i + 1 - count);
                found = 1'b1;
              end
            end
          end
          if (found) begin
            claim_sectors(r.sector, count);
          end else if (water_mark + count > SECTORS) begin
            r.status = STATUS_FULL;
          end else begin
            r.sector = SEC_W'(water_mark);
            claim_sectors(water_mark, count);
          end
        end
      end
      CMD_FREE: begin
        if (count != 0) write_sectors(start, count, 1'b0);
      end
      CMD_RESERVE: begin
        if (count != 0) begin
          if (count > MAX_RUN || start + count > SECTORS) r.status = STATUS_FULL;
          else claim_sectors(start, count);
        end
      end
      default: begin
        r.is_used = (start < SECTORS) ? sector_used[start] : 1'b0;
      end
    endcase
    return r;
  endfunction

  // compare replies first, then record new requests
  always @(posedge clk) begin : watch
    reply_fields_t want;
    reply_fields_t got;
    int            bad;
    bad = 0;
    if (rst) begin
      foreach (sector_used[i]) sector_used[i] = 1'b0;
      water_mark = 0;
      expected_replies.delete();
      errors <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.sector  = m_tdata[SEC_W-1:0];
        got.is_used = m_tdata[SEC_W];
        got.status  = m_tdata[SEC_W+1];
        if (expected_replies.size() == 0) begin
          $error("reply with no request waiting: data %h", m_tdata);
          bad++;
        end else begin
          want = expected_replies.pop_front();
          if (got.sector !== want.sector) begin
            $error("sector mismatch: expected %0d, actual %0d", want.sector, got.sector);
            bad++;
          end
          if (got.is_used !== want.is_used) begin
            $error("is_used mismatch: expected %0d, actual %0d", want.is_used, got.is_used);
            bad++;
          end
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            bad++;
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_replies.push_back(predict_reply(cmd_t'(s_tuser),
                                                 s_tdata[START_W-1:0],
                                                 s_tdata[START_W+COUNT_W-1:START_W]));
      errors <= errors + bad;
    end
    pending <= expected_replies.size();
  end

endmodule

### bench/testbench.sv
// testbench: drives allocate, free, reserve and test requests into the
// sector allocator with random idling on both sides and reports the verdict.
// Depends on bffa_pkg, bitmap_first_fit_sector_allocator, sector_alloc_monitor.
`timescale 1ns / 1ps

module testbench;
  import bffa_pkg::*;

  localparam int RANDOM_ITEMS = 550;
  localparam int MAX_IDLE     = 12;
  localparam int DRAIN_CYCLES = 1200;
  localparam int CYCLE_LIMIT  = 3000000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  int                    errors;
  int                    pending;
  bit                    sender_steady = 1'b0;
  bit                    receiver_steady = 1'b0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bitmap_first_fit_sector_allocator DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  sector_alloc_monitor monitor (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending)
  );

  // one request: idle gap, then hold until accepted
  task automatic issue_request(cmd_t cmd, int unsigned start, int unsigned count);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {3'b000, count[COUNT_W-1:0], start[START_W-1:0]};
    do @(posedge clk); while (!s_tready);
  endtask

  // wait until every expected reply has come back
  task automatic wait_replies();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // reply side: random stalls per reply, with steady stretches
  initial begin : reply_sink
    int stall;
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      stall = receiver_steady ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      taken++;
      if (taken % 30 == 0) receiver_steady = ($urandom_range(0, 2) == 0);
    end
  end

  // run limit
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // stimulus and verdict
  initial begin : stimulus
    int          n;
    int unsigned pick;
    int unsigned start;
    int unsigned count;
    cmd_t        cmd;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: low sectors while the mark is small, zero counts, capacity edges
    issue_request(CMD_ALLOC,   0,    0);
    issue_request(CMD_ALLOC,   0,    1);
    issue_request(CMD_ALLOC,   8191, 3);
    issue_request(CMD_TEST,    0,    0);
    issue_request(CMD_TEST,    1,    255);
    issue_request(CMD_FREE,    0,    1);
    issue_request(CMD_ALLOC,   0,    1);
    issue_request(CMD_FREE,    0,    0);
    issue_request(CMD_RESERVE, 10,   0);
    issue_request(CMD_RESERVE, 0,    2);
    issue_request(CMD_FREE,    2,    2);
    issue_request(CMD_ALLOC,   0,    2);
    issue_request(CMD_TEST,    0,    0);
    issue_request(CMD_RESERVE, 8191, 255);
    issue_request(CMD_RESERVE, 8000, 255);
    issue_request(CMD_FREE,    8100, 255);
    issue_request(CMD_TEST,    8191, 0);
    issue_request(CMD_ALLOC,   0,    255);
    issue_request(CMD_RESERVE, 100,  255);
    issue_request(CMD_ALLOC,   0,    200);
    issue_request(CMD_FREE,    120,  40);
    issue_request(CMD_ALLOC,   0,    30);
    issue_request(CMD_ALLOC,   0,    0);

    // random mix, with a full drain halfway through
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) sender_steady = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) begin
        s_tvalid <= 1'b0;
        wait_replies();
      end
      pick = $urandom_range(0, 9);
      cmd = (pick < 4) ? CMD_ALLOC : (pick < 6) ? CMD_RESERVE :
            (pick < 8) ? CMD_FREE : CMD_TEST;
      start = $urandom_range(0, 1) ? $urandom_range(0, 8191) : $urandom_range(0, 1023);
      pick = $urandom_range(0, 19);
      if (pick == 0) count = 0;
      else if (pick < 4) count = $urandom_range(200, 255);
      else count = $urandom_range(1, 24);
      issue_request(cmd, start, count);
    end

    // fill up to capacity and probe the top of the map
    issue_request(CMD_RESERVE, 7937, 255);
    issue_request(CMD_ALLOC,   0,    255);
    issue_request(CMD_ALLOC,   0,    255);
    issue_request(CMD_ALLOC,   0,    255);
    issue_request(CMD_ALLOC,   0,    0);
    issue_request(CMD_TEST,    8191, 0);
    s_tvalid <= 1'b0;

    wait_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
